/* rtl/sioj_pkg.sv */
// ----------------------------------------------------------------------------
// sioj_pkg
// Shared types and constants for the sorted interval overlap join block.
// ----------------------------------------------------------------------------
package sioj_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int ID_W    = 20;

    // default sizing
    localparam int DB_DEPTH_DEF = 4096;
    localparam int MAX_HITS_DEF = 64;

    // one stored database entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] end_c;
        logic [COORD_W-1:0] start_c;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // input transaction kinds
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

/* rtl/sorted_interval_overlap_join_top.sv */
// ----------------------------------------------------------------------------
// sorted_interval_overlap_join_top
// Joins query intervals against a store of sorted database intervals and
// streams out the (query id, entry id) pair of every overlap.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                  tuser       tlast
//  s_*      in   start[31:0] end[63:32] id[83:64]    opcode      -
//  m_*      out  query_id[19:0] match_id[39:20]      truncated   last pair
//
//  clear and load transactions are handled in the idle state; a load writes the store unless it is full.
//  a query walks the entries from the resume index onward: the store read
//  port delivers one entry per cycle while the output does not stall, its read
//  data is registered, and a flush state then releases the held final pair.
//  the input is taken only between queries; a stalled output stalls the walk.
//  reset clears fill count and resume index, the store itself is not cleared.
//
module sorted_interval_overlap_join_top #(
    parameter int DB_DEPTH = sioj_pkg::DB_DEPTH_DEF,
    parameter int MAX_HITS = sioj_pkg::MAX_HITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // interval_start, interval_end, item_id, zero pad
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // query_id, match_id
    output logic        m_tlast,   // last
    output logic        m_tuser    // truncated
);

    localparam int AW     = $clog2(DB_DEPTH);
    localparam int FILL_W = $clog2(DB_DEPTH + 1);
    localparam int HIT_W  = $clog2(MAX_HITS + 1);
    localparam int CW     = sioj_pkg::COORD_W;
    localparam int IW     = sioj_pkg::ID_W;

    // input field split
    logic [CW-1:0] in_start;
    logic [CW-1:0] in_end;
    logic [IW-1:0] in_id;
    assign in_start = s_tdata[CW-1:0];
    assign in_end   = s_tdata[2*CW-1:CW];
    assign in_id    = s_tdata[2*CW+IW-1:2*CW];

    // registers
    sioj_pkg::state_t  state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [AW-1:0]     resume_reg, resume_next;
    logic [FILL_W-1:0] issue_reg, issue_next;
    logic [AW-1:0]     eval_pos_reg, eval_pos_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [HIT_W-1:0]  hits_reg, hits_next;
    logic              dropped_reg, dropped_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IW-1:0]     pend_id_reg, pend_id_next;
    logic [CW-1:0]     q_lo_reg, q_lo_next;
    logic [CW-1:0]     q_hi_reg, q_hi_next;
    logic [IW-1:0]     q_id_reg, q_id_next;
    logic              out_valid_reg, out_valid_next;
    logic [IW-1:0]     out_qid_reg, out_qid_next;
    logic [IW-1:0]     out_mid_reg, out_mid_next;
    logic              out_last_reg, out_last_next;
    logic              out_trunc_reg, out_trunc_next;

    // store ports
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    sioj_pkg::entry_t          wr_entry;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [sioj_pkg::ENTRY_W-1:0] rd_data;
    sioj_pkg::entry_t          rd_entry;

    assign rd_entry = sioj_pkg::entry_t'(rd_data);

    sioj_ram #(
        .WIDTH (sioj_pkg::ENTRY_W),
        .DEPTH (DB_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // scan decisions on the entry under evaluation
    logic out_free;
    logic brk;
    logic miss_low;
    logic overlap;
    logic take_hit;
    logic stall;
    logic advance;
    logic more;

    assign out_free = !out_valid_reg || m_tready;
    assign brk      = eval_valid_reg && (rd_entry.start_c > q_hi_reg);
    assign miss_low = eval_valid_reg && !brk && (rd_entry.end_c < q_lo_reg);
    assign overlap  = eval_valid_reg && !brk && !miss_low;
    assign take_hit = overlap && (hits_reg < HIT_W'(MAX_HITS));
    assign stall    = take_hit && pend_valid_reg && !out_free;
    assign advance  = !stall;
    assign more     = issue_reg < fill_reg;

    assign s_tready = (state_reg == sioj_pkg::ST_IDLE);

    // next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        resume_next     = resume_reg;
        issue_next      = issue_reg;
        eval_pos_next   = eval_pos_reg;
        eval_valid_next = eval_valid_reg;
        hits_next       = hits_reg;
        dropped_next    = dropped_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        q_lo_next       = q_lo_reg;
        q_hi_next       = q_hi_reg;
        q_id_next       = q_id_reg;
        out_qid_next    = out_qid_reg;
        out_mid_next    = out_mid_reg;
        out_last_next   = out_last_reg;
        out_trunc_next  = out_trunc_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        wr_en           = 1'b0;
        wr_addr         = fill_reg[AW-1:0];
        wr_entry        = '{id: in_id, end_c: in_end, start_c: in_start};
        rd_en           = 1'b0;
        rd_addr         = issue_reg[AW-1:0];

        unique case (state_reg)
            sioj_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        sioj_pkg::OP_CLEAR:
                        begin
                            fill_next   = '0;
                            resume_next = '0;
                        end
                        sioj_pkg::OP_LOAD:
                        begin
                            if (fill_reg < FILL_W'(DB_DEPTH))
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        sioj_pkg::OP_QUERY:
                        begin
                            q_lo_next       = in_start;
                            q_hi_next       = in_end;
                            q_id_next       = in_id;
                            issue_next      = {{(FILL_W-AW){1'b0}}, resume_reg};
                            eval_valid_next = 1'b0;
                            hits_next       = '0;
                            dropped_next    = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = sioj_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            // unused opcode, no effect
                        end
                    endcase
                end
            end

            sioj_pkg::ST_SCAN:
            begin
                if (advance)
                begin
                    // consume the entry under evaluation
                    if (miss_low)
                    begin
                        resume_next = eval_pos_reg;
                    end
                    if (overlap)
                    begin
                        if (take_hit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_qid_next   = q_id_reg;
                                out_mid_next   = pend_id_reg;
                                out_last_next  = 1'b0;
                                out_trunc_next = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_id_next    = rd_entry.id;
                            hits_next       = hits_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    // issue the next read or finish the walk
                    if (brk || !more)
                    begin
                        eval_valid_next = 1'b0;
                        state_next      = sioj_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        eval_valid_next = 1'b1;
                        eval_pos_next   = issue_reg[AW-1:0];
                        issue_next      = issue_reg + 1'b1;
                    end
                end
            end

            sioj_pkg::ST_FLUSH:
            begin
                // release the held final pair with its flags
                if (!pend_valid_reg)
                begin
                    state_next = sioj_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_qid_next    = q_id_reg;
                    out_mid_next    = pend_id_reg;
                    out_last_next   = 1'b1;
                    out_trunc_next  = dropped_reg;
                    pend_valid_next = 1'b0;
                    state_next      = sioj_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sioj_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sioj_pkg::ST_IDLE;
            fill_reg       <= '0;
            resume_reg     <= '0;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            resume_reg     <= resume_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        issue_reg     <= issue_next;
        eval_pos_reg  <= eval_pos_next;
        hits_reg      <= hits_next;
        dropped_reg   <= dropped_next;
        pend_id_reg   <= pend_id_next;
        q_lo_reg      <= q_lo_next;
        q_hi_reg      <= q_hi_next;
        q_id_reg      <= q_id_next;
        out_qid_reg   <= out_qid_next;
        out_mid_reg   <= out_mid_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    // output transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_mid_reg, out_qid_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_trunc_reg;

endmodule

/* rtl/sioj_ram.sv */
// ----------------------------------------------------------------------------
// sioj_ram
// Generic simple dual port RAM, one write port, one registered read port
// with read enable (read data holds while the enable is low).
// ----------------------------------------------------------------------------
module sioj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sim/tb_sorted_interval_overlap_join_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_interval_overlap_join_top
// Streams clear, load and query transactions into the interval join block and
// checks every (query id, entry id) pair against an in-bench join predictor.
// Directed tests cover extreme coordinates, touching endpoints, resume index
// behavior, the unused opcode, unsorted and inverted intervals and the hit
// limit. A short random phase follows, mostly sorted runs with random content
// plus noise and broken runs. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sorted_interval_overlap_join_top;

    localparam int DEPTH        = sioj_pkg::DB_DEPTH_DEF;
    localparam int HITS         = sioj_pkg::MAX_HITS_DEF;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 12;
    localparam int REPORT_MAX   = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one overlap pair as seen on the output stream
    typedef struct packed {
        logic [sioj_pkg::ID_W-1:0] query_id;
        logic [sioj_pkg::ID_W-1:0] match_id;
        logic                      is_last;
        logic                      truncated;
    } pair_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // predictor copy of the interval store
    logic [sioj_pkg::COORD_W-1:0] lo_mem  [DEPTH];
    logic [sioj_pkg::COORD_W-1:0] hi_mem  [DEPTH];
    logic [sioj_pkg::ID_W-1:0]    tag_mem [DEPTH];
    int stored_count = 0;
    int scan_from    = 0;

    pair_t pending_pairs[$];
    int items_taken       = 0;
    int pairs_predicted   = 0;
    int pairs_seen        = 0;
    int truncated_queries = 0;
    int pair_mismatches   = 0;
    int idle_cycles       = 0;
    bit src_gaps          = 1'b1;
    bit sink_stalls       = 1'b1;

    sorted_interval_overlap_join_top #(
        .DB_DEPTH (DEPTH),
        .MAX_HITS (HITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // join predictor: applies one accepted transaction, queues its pairs
    task automatic join_interval(input logic [1:0] op,
                                 input logic [sioj_pkg::COORD_W-1:0] lo,
                                 input logic [sioj_pkg::COORD_W-1:0] hi,
                                 input logic [sioj_pkg::ID_W-1:0] tag);
        pair_t found[$];
        pair_t p;
        bit    dropped;
        dropped = 1'b0;
        items_taken++;
        case (op)
            sioj_pkg::OP_CLEAR:
            begin
                stored_count = 0;
                scan_from    = 0;
            end
            sioj_pkg::OP_LOAD:
            begin
                // a load into a full store is dropped
                if (stored_count < DEPTH)
                begin
                    lo_mem[stored_count]  = lo;
                    hi_mem[stored_count]  = hi;
                    tag_mem[stored_count] = tag;
                    stored_count++;
                end
            end
            sioj_pkg::OP_QUERY:
            begin
                for (int pos = scan_from; pos < stored_count; pos++)
                begin
                    if (lo_mem[pos] > hi)
                        break;
                    else if (hi_mem[pos] < lo)
                        scan_from = pos;
                    else if (found.size() < HITS)
                    begin
                        p.query_id  = tag;
                        p.match_id  = tag_mem[pos];
                        p.is_last   = 1'b0;
                        p.truncated = 1'b0;
                        found.push_back(p);
                    end
                    else
                        dropped = 1'b1;
                end
                if (found.size() > 0)
                begin
                    found[found.size()-1].is_last   = 1'b1;
                    found[found.size()-1].truncated = dropped;
                    if (dropped)
                        truncated_queries++;
                    foreach (found[i])
                        pending_pairs.push_back(found[i]);
                    pairs_predicted += found.size();
                end
            end
            default:
                ; // unused opcode leaves all state alone
        endcase
    endtask

    // send one transaction after a random gap, predict on acceptance
    task automatic send_item(input logic [1:0] op,
                             input logic [sioj_pkg::COORD_W-1:0] lo,
                             input logic [sioj_pkg::COORD_W-1:0] hi,
                             input logic [sioj_pkg::ID_W-1:0] tag);
        int gap;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, tag, hi, lo};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        join_interval(op, lo, hi, tag);
        @(negedge clk);
    endtask

    // stop sending, wait for all pairs, then let any trailing scan finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(negedge clk);
        repeat (stored_count + 16) @(negedge clk);
    endtask

    // extremes of coordinates and ids, touching endpoints
    task automatic test_edges();
        send_item(sioj_pkg::OP_CLEAR, '0, '0, '0);
        send_item(sioj_pkg::OP_LOAD, 32'd0, 32'd0, 20'd0);
        send_item(sioj_pkg::OP_LOAD, 32'd0, 32'd10, 20'd1);
        send_item(sioj_pkg::OP_LOAD, 32'd5, 32'd5, 20'hFFFFF);
        send_item(sioj_pkg::OP_LOAD, 32'd20, 32'hFFFF_FFFF, 20'd2);
        send_item(sioj_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd3);
        send_item(sioj_pkg::OP_QUERY, 32'd0, 32'd0, 20'hFFFFF);
        send_item(sioj_pkg::OP_QUERY, 32'd5, 32'd20, 20'd1);
        send_item(sioj_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd0);
        send_item(sioj_pkg::OP_QUERY, 32'd0, 32'hFFFF_FFFF, 20'd7);
        wait_idle();
    endtask

    // queries without overlap still move the resume index
    task automatic test_no_overlap();
        send_item(sioj_pkg::OP_CLEAR, '0, '0, '0);
        send_item(sioj_pkg::OP_LOAD, 32'd100, 32'd110, 20'd11);
        send_item(sioj_pkg::OP_LOAD, 32'd200, 32'd210, 20'd12);
        send_item(sioj_pkg::OP_LOAD, 32'd300, 32'd310, 20'd13);
        send_item(sioj_pkg::OP_QUERY, 32'd150, 32'd160, 20'd21);
        send_item(sioj_pkg::OP_QUERY, 32'd400, 32'd500, 20'd22);
        send_item(sioj_pkg::OP_QUERY, 32'd100, 32'd105, 20'd23);
        send_item(sioj_pkg::OP_QUERY, 32'd0, 32'd50, 20'd24);
        send_item(sioj_pkg::OP_CLEAR, '0, '0, '0);
        send_item(sioj_pkg::OP_QUERY, 32'd0, 32'hFFFF_FFFF, 20'd25);
        wait_idle();
    endtask

    // opcode 3 must change nothing and return nothing
    task automatic test_unused_opcode();
        send_item(sioj_pkg::OP_CLEAR, '0, '0, '0);
        send_item(sioj_pkg::OP_LOAD, 32'd10, 32'd20, 20'd5);
        send_item(OP_UNUSED, 32'd0, 32'd100, 20'd9);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
        send_item(sioj_pkg::OP_QUERY, 32'd15, 32'd15, 20'd4);
        wait_idle();
    endtask

    // unsorted loads and inverted intervals go through the same compares
    task automatic test_unsorted();
        send_item(sioj_pkg::OP_CLEAR, '0, '0, '0);
        send_item(sioj_pkg::OP_LOAD, 32'd50, 32'd40, 20'd1);
        send_item(sioj_pkg::OP_LOAD, 32'd10, 32'd60, 20'd2);
        send_item(sioj_pkg::OP_LOAD, 32'd30, 32'd30, 20'd3);
        send_item(sioj_pkg::OP_QUERY, 32'd35, 32'd45, 20'd8);
        send_item(sioj_pkg::OP_QUERY, 32'd60, 32'd40, 20'd9);
        send_item(sioj_pkg::OP_QUERY, 32'd40, 32'd70, 20'd10);
        send_item(sioj_pkg::OP_QUERY, 32'd25, 32'd35, 20'd11);
        wait_idle();
    endtask

    // exactly the hit limit, then one query over the limit
    task automatic test_hit_limit();
        send_item(sioj_pkg::OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < HITS; i++)
            send_item(sioj_pkg::OP_LOAD, 32'd1000, 32'd2000, sioj_pkg::ID_W'(i + 100));
        send_item(sioj_pkg::OP_LOAD, 32'd3000, 32'd3000, 20'd500);
        send_item(sioj_pkg::OP_LOAD, 32'd3000, 32'd3100, 20'd501);
        send_item(sioj_pkg::OP_QUERY, 32'd1500, 32'd1500, 20'd31);
        send_item(sioj_pkg::OP_QUERY, 32'd0, 32'd4000, 20'd32);
        send_item(sioj_pkg::OP_QUERY, 32'd2500, 32'd3000, 20'd33);
        wait_idle();
    endtask

    // sorted runs with random content, noise and broken runs
    task automatic test_random();
        int                           first_items;
        int                           kind;
        logic [sioj_pkg::COORD_W-1:0] base;
        logic [sioj_pkg::COORD_W-1:0] s;
        first_items = items_taken;
        while (items_taken - first_items < RANDOM_ITEMS)
        begin
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            kind        = $urandom_range(0, 9);
            if (kind < 7)
            begin
                // well-formed run: sorted loads then sorted queries
                case ($urandom_range(0, 7))
                    0:       base = '0;
                    1:       base = 32'hFFFF_FF00;
                    default: base = $urandom_range(0, 32'hFFFF_FF00);
                endcase
                if ($urandom_range(0, 4) != 0)
                    send_item(sioj_pkg::OP_CLEAR, $urandom, $urandom,
                              sioj_pkg::ID_W'($urandom));
                s = base;
                repeat ($urandom_range(1, 12))
                begin
                    s = s + $urandom_range(0, 8);
                    send_item(sioj_pkg::OP_LOAD, s, s + $urandom_range(0, 12),
                              sioj_pkg::ID_W'($urandom));
                end
                s = base;
                repeat ($urandom_range(1, 6))
                begin
                    s = s + $urandom_range(0, 10);
                    send_item(sioj_pkg::OP_QUERY, s, s + $urandom_range(0, 16),
                              sioj_pkg::ID_W'($urandom));
                    if ($urandom_range(0, 15) == 0)
                        send_item(OP_UNUSED, $urandom, $urandom,
                                  sioj_pkg::ID_W'($urandom));
                end
            end
            else if (kind < 9)
            begin
                // noise: any opcode, any coordinates
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom), $urandom, $urandom, sioj_pkg::ID_W'($urandom));
            end
            else
            begin
                // broken run: descending starts, some inverted intervals
                s = $urandom_range(32'h100, 32'hFFFF_FFFF);
                repeat ($urandom_range(2, 8))
                begin
                    s = s - $urandom_range(0, 8);
                    if ($urandom_range(0, 1) == 0)
                        send_item(sioj_pkg::OP_LOAD, s, s - $urandom_range(0, 4),
                                  sioj_pkg::ID_W'($urandom));
                    else
                        send_item(sioj_pkg::OP_LOAD, s, s + $urandom_range(0, 20),
                                  sioj_pkg::ID_W'($urandom));
                end
                send_item(sioj_pkg::OP_QUERY, s, s + 40, sioj_pkg::ID_W'($urandom));
                send_item(sioj_pkg::OP_QUERY, s + 60, s - 8, sioj_pkg::ID_W'($urandom));
            end
            if ($urandom_range(0, 3) == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    // output side: random stall before each transaction
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = sink_stalls ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // compare each output transaction with the oldest expected pair
    always @(posedge clk)
    begin
        pair_t got;
        pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[sioj_pkg::ID_W-1:0], m_tdata[2*sioj_pkg::ID_W-1:sioj_pkg::ID_W],
                   m_tlast, m_tuser};
            pairs_seen++;
            if (pending_pairs.size() == 0)
            begin
                pair_mismatches++;
                if (pair_mismatches <= REPORT_MAX)
                    $display("unexpected output transaction: query %0h match %0h %s %0b %s %0b",
                             got.query_id, got.match_id, "last", got.is_last,
                             "trunc", got.truncated);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (got !== want)
                begin
                    pair_mismatches++;
                    if (pair_mismatches <= REPORT_MAX)
                    begin
                        $display("mismatch: expected query %0h match %0h last %0b trunc %0b",
                                 want.query_id, want.match_id, want.is_last, want.truncated);
                        $display("          actual   query %0h match %0h last %0b trunc %0b",
                                 got.query_id, got.match_id, got.is_last, got.truncated);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without a transaction", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = sioj_pkg::OP_CLEAR;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_edges();
        test_no_overlap();
        test_unused_opcode();
        test_unsorted();
        test_hit_limit();
        test_random();

        if (pending_pairs.size() != 0)
        begin
            $display("%0d expected pairs never arrived", pending_pairs.size());
            pair_mismatches += pending_pairs.size();
        end
        $display("run covered %0d input transactions, %0d pairs predicted, %0d pairs checked",
                 items_taken, pairs_predicted, pairs_seen);
        $display("%0d truncated queries, %0d mismatches", truncated_queries, pair_mismatches);
        if (pair_mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
